@@ hw/rtl/ogi_pkg.sv @@
// Package for the offset gap infill block.
// Payload structs, fill limit and controller/datapath command and status types.
// No dependencies.
package ogi_pkg;

    localparam int MAX_FILL   = 63;
    localparam int OFS_W      = 32;
    localparam int STEP_W     = 31;
    localparam int CNT_W      = 6;
    localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(256);

    typedef struct packed {
        logic signed [OFS_W-1:0] offset;
        logic                    last_sample;
    } t_in;

    typedef struct packed {
        logic signed [OFS_W-1:0] offset_out;
        logic                    filled;
        logic                    fill_capped;
        logic                    order_error;
        logic                    run_last;
    } t_out;

    typedef struct packed {
        logic load_in;
        logic calc_delta;
        logic calc_test;
        logic emit_fill;
        logic emit_final;
    } t_cmd;

    typedef struct packed {
        logic fill_more;
        logic out_free;
    } t_status;

endpackage

@@ hw/rtl/offset_gap_infill.sv @@
// Top level of the offset gap infill block.
// Joins ogi_ctrl and ogi_dp; depends on ogi_pkg.
//
//   channel  direction  handshake                 payload
//   in       input      i_in_valid / o_in_stall   i_in_data  (t_in)
//   out      output     o_out_valid / i_out_stall o_out_data (t_out)
//   cfg      input      i_cfg_we                  i_cfg_wdata (step)
//
// An input transaction runs through capture, delta, gap compare, end-of-fill check and
// final result when no fill is needed; a gap adds fill points, up to 63 per sample.
// The output register frees the input side while a result waits; a
// stalled output holds the fill run. Synchronous active-low reset; step resets to 256.
module offset_gap_infill (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  ogi_pkg::t_in                i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ogi_pkg::t_out               o_out_data,
    input  logic                        i_cfg_we,
    input  logic [ogi_pkg::STEP_W-1:0]  i_cfg_wdata
);
    import ogi_pkg::*;

    t_cmd    cmd;
    t_status status;

    ogi_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    ogi_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ hw/rtl/ogi_ctrl.sv @@
// Controller state machine for the offset gap infill block.
// Sequences capture, delta, gap test, fill run and final result.
// Depends on ogi_pkg.
module ogi_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ogi_pkg::t_status i_status,
    output ogi_pkg::t_cmd    o_cmd
);
    import ogi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DELTA = 3'd1;
    localparam logic [2:0] S_TEST  = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DELTA;
                end
            end
            S_DELTA: begin
                o_cmd.calc_delta = 1'b1;
                n_state          = S_TEST;
            end
            S_TEST: begin
                o_cmd.calc_test = 1'b1;
                n_state         = S_FILL;
            end
            S_FILL: begin
                if (!i_status.fill_more) begin
                    n_state = S_EMIT;
                end else if (i_status.out_free) begin
                    o_cmd.emit_fill = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_final = 1'b1;
                    n_state          = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ hw/rtl/ogi_dp.sv @@
// Datapath for the offset gap infill block.
// Line state, step register, delta and gap compare, fill accumulator, output register.
// Depends on ogi_pkg.
module ogi_dp (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ogi_pkg::t_in                i_in_data,
    input  logic                        i_cfg_we,
    input  logic [ogi_pkg::STEP_W-1:0]  i_cfg_wdata,
    input  ogi_pkg::t_cmd               i_cmd,
    output ogi_pkg::t_status            o_status,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output ogi_pkg::t_out               o_out_data
);
    import ogi_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [OFS_W-1:0]  r_prev;
    logic              r_have_prev;
    logic [OFS_W-1:0]  r_x;
    logic              r_last;
    logic [OFS_W:0]    r_delta;
    logic              r_gap;
    logic              r_capped;
    logic [OFS_W:0]    r_acc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    t_out              r_out;

    logic [STEP_W-1:0] s_eff;
    logic [OFS_W-1:0]  d;
    logic [35:0]       d10;
    logic [35:0]       s19;
    logic [36:0]       s64;
    logic              out_free;
    logic              fill_more;

    assign s_eff = (r_step == '0) ? STEP_W'(1) : r_step;
    assign d     = r_delta[OFS_W-1:0];
    assign d10   = {1'b0, d, 3'b000} + {3'b000, d, 1'b0};
    assign s19   = {1'b0, s_eff, 4'b0000} + {4'b0000, s_eff, 1'b0} + {5'b00000, s_eff};
    assign s64   = {s_eff, 6'b000000};

    assign out_free  = !r_out_valid || !i_out_stall;
    assign fill_more = r_gap && (r_acc < {1'b0, d}) && (r_cnt != CNT_W'(MAX_FILL));

    assign o_status.fill_more = fill_more;
    assign o_status.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_RESET;
            r_prev      <= '0;
            r_have_prev <= 1'b0;
            r_cnt       <= '0;
            r_gap       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_step <= i_cfg_wdata;
            end
            if (i_cmd.load_in) begin
                r_x    <= i_in_data.offset;
                r_last <= i_in_data.last_sample;
            end
            if (i_cmd.calc_delta) begin
                r_delta <= {r_x[OFS_W-1], r_x} - {r_prev[OFS_W-1], r_prev};
            end
            if (i_cmd.calc_test) begin
                r_gap    <= r_have_prev && !r_delta[OFS_W] && (d10 > s19);
                r_capped <= r_have_prev && !r_delta[OFS_W] && (d10 > s19)
                            && ({5'b00000, d} > s64);
                r_acc    <= {2'b00, s_eff};
                r_cnt    <= '0;
            end

            if (!i_out_stall && !i_cmd.emit_fill && !i_cmd.emit_final) begin
                r_out_valid <= 1'b0;
            end

            if (i_cmd.emit_fill) begin
                r_out.offset_out  <= r_prev + r_acc[OFS_W-1:0];
                r_out.filled      <= 1'b1;
                r_out.fill_capped <= r_capped;
                r_out.order_error <= 1'b0;
                r_out.run_last    <= 1'b0;
                r_out_valid       <= 1'b1;
                r_acc             <= r_acc + {2'b00, s_eff};
                r_cnt             <= r_cnt + CNT_W'(1);
            end

            if (i_cmd.emit_final) begin
                r_out.filled   <= 1'b0;
                r_out.run_last <= 1'b1;
                r_out_valid    <= 1'b1;
                r_cnt          <= '0;
                r_gap          <= 1'b0;
                if (r_have_prev && r_delta[OFS_W]) begin
                    r_out.offset_out  <= '0;
                    r_out.fill_capped <= 1'b0;
                    r_out.order_error <= 1'b1;
                end else begin
                    r_out.offset_out  <= r_x;
                    r_out.fill_capped <= r_capped;
                    r_out.order_error <= 1'b0;
                end
                if (r_last) begin
                    r_prev      <= '0;
                    r_have_prev <= 1'b0;
                end else if (!(r_have_prev && r_delta[OFS_W])) begin
                    r_prev      <= r_x;
                    r_have_prev <= 1'b1;
                end
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ tb/tb_offset_gap_infill.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for offset_gap_infill: directed and random offset lines against a gap-fill predictor.
// Depends on ogi_pkg and the offset_gap_infill RTL only.
module tb_offset_gap_infill;
    import ogi_pkg::*;

    localparam int unsigned QUIET_LIMIT = 3000;
    localparam int unsigned DRAIN_WAIT  = 10;
    localparam int unsigned PHASE_ITEMS = 36;
    localparam longint OFS_MAX = 64'sd2147483647;
    localparam longint OFS_MIN = -64'sd2147483648;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    logic               o_in_stall;
    t_in                i_in_data   = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    t_out               o_out_data;
    logic               i_cfg_we    = 1'b0;
    logic [STEP_W-1:0]  i_cfg_wdata = '0;

    offset_gap_infill u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    wire in_fire  = i_in_valid && !o_in_stall;
    wire out_fire = o_out_valid && !i_out_stall;

    t_in  offset_q[$];
    t_out axis_q[$];

    // predictor state
    logic [STEP_W-1:0]    step_reg  = STEP_RESET;
    logic signed [31:0]   prev_ofs  = '0;
    logic                 line_open = 1'b0;

    bit          idle_on   = 1'b1;
    bit          in_taken  = 1'b0;
    int unsigned in_gap    = 0;
    int unsigned stall_left = 0;
    int unsigned quiet     = 0;

    int unsigned n_mismatch = 0;
    int unsigned n_items    = 0;
    int unsigned n_results  = 0;
    int unsigned n_fills    = 0;
    int unsigned n_capped   = 0;
    int unsigned n_order    = 0;
    int unsigned n_cfg      = 0;

    // generator line state
    longint gen_cur;

    task automatic report_mismatch(string msg);
        n_mismatch++;
        if (n_mismatch <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    function automatic t_out make_point(logic signed [31:0] ofs, logic fil, logic cap,
                                        logic err, logic lst);
        t_out r;
        r.offset_out  = ofs;
        r.filled      = fil;
        r.fill_capped = cap;
        r.order_error = err;
        r.run_last    = lst;
        return r;
    endfunction

    function automatic void predict_axis(t_in it);
        longint            x, p, d;
        longint unsigned   s, ud, nfill;
        logic              capped;
        logic signed [31:0] v;
        x = it.offset;
        if (!line_open) begin
            axis_q.push_back(make_point(it.offset, 1'b0, 1'b0, 1'b0, 1'b1));
            prev_ofs  = it.offset;
            line_open = 1'b1;
        end else begin
            p = prev_ofs;
            d = x - p;
            if (d < 0) begin
                axis_q.push_back(make_point('0, 1'b0, 1'b0, 1'b1, 1'b1));
            end else begin
                s      = (step_reg == '0) ? 64'd1 : 64'(step_reg);
                ud     = d;
                nfill  = 0;
                capped = 1'b0;
                if (ud * 10 > s * 19) begin
                    nfill = ud / s;
                    if (nfill * s == ud) nfill--;
                    if (nfill > MAX_FILL) begin
                        nfill  = MAX_FILL;
                        capped = 1'b1;
                    end
                end
                for (longint unsigned k = 1; k <= nfill; k++) begin
                    v = 32'(p + longint'(k * s));
                    axis_q.push_back(make_point(v, 1'b1, capped, 1'b0, 1'b0));
                end
                axis_q.push_back(make_point(it.offset, 1'b0, capped, 1'b0, 1'b1));
                prev_ofs = it.offset;
            end
        end
        if (it.last_sample) begin
            prev_ofs  = '0;
            line_open = 1'b0;
        end
    endfunction

    // input side: acceptance and prediction
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && in_fire;
        if (i_rst_n && in_fire) begin
            predict_axis(i_in_data);
            n_items++;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        if (!i_in_valid || in_taken) begin
            if (in_gap > 0) begin
                in_gap--;
                i_in_valid <= 1'b0;
            end else if (offset_q.size() > 0) begin
                i_in_data  <= offset_q.pop_front();
                i_in_valid <= 1'b1;
                if (idle_on && $urandom_range(0, 4) == 0) in_gap = $urandom_range(1, 10);
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall driver
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 9);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // output monitor
    always @(posedge i_clk) begin : monitor
        t_out got;
        t_out want;
        if (i_rst_n && out_fire) begin
            got = o_out_data;
            n_results++;
            if (got.filled) n_fills++;
            if (got.fill_capped) n_capped++;
            if (got.order_error) n_order++;
            if (axis_q.size() == 0) begin
                report_mismatch($sformatf("unexpected transaction offset_out=%0d",
                                          got.offset_out));
            end else begin
                want = axis_q.pop_front();
                if (got.offset_out !== want.offset_out)
                    report_mismatch($sformatf("offset_out got %0d want %0d",
                                              got.offset_out, want.offset_out));
                if (got.filled !== want.filled)
                    report_mismatch($sformatf("filled got %b want %b at offset %0d",
                                              got.filled, want.filled, want.offset_out));
                if (got.fill_capped !== want.fill_capped)
                    report_mismatch($sformatf("fill_capped got %b want %b at offset %0d",
                                              got.fill_capped, want.fill_capped,
                                              want.offset_out));
                if (got.order_error !== want.order_error)
                    report_mismatch($sformatf("order_error got %b want %b at offset %0d",
                                              got.order_error, want.order_error,
                                              want.offset_out));
                if (got.run_last !== want.run_last)
                    report_mismatch($sformatf("run_last got %b want %b at offset %0d",
                                              got.run_last, want.run_last, want.offset_out));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n || in_fire || out_fire || i_cfg_we) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", quiet);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic push_item(longint ofs, bit lst);
        t_in it;
        it.offset      = 32'(ofs);
        it.last_sample = lst;
        offset_q.push_back(it);
    endtask

    task automatic write_step(logic [STEP_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        step_reg = val;
        n_cfg++;
    endtask

    task automatic drain();
        while (offset_q.size() > 0 || i_in_valid || axis_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // one line of offsets; mostly increasing with gaps sized against the step
    task automatic push_line(int unsigned len);
        longint unsigned s;
        longint          d, nx;
        int unsigned     pick, hi, i;
        s = (step_reg == '0) ? 64'd1 : 64'(step_reg);
        for (i = 0; i < len; i++) begin
            if (i == 0) begin
                pick = $urandom_range(0, 3);
                if (pick == 0) nx = longint'(signed'(32'($urandom)));
                else if (s > 64'd1000000) nx = OFS_MIN + $urandom_range(0, 1000);
                else nx = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
                gen_cur = nx;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 8) begin
                    hi = (s > 64'd1000000) ? 32'h7FFFFFFF : int'(3 * s);
                    d  = -longint'($urandom_range(1, hi));
                end else if (pick < 18) begin
                    d = 0;
                end else if (pick < 38) begin
                    hi = int'((19 * s) / 10);
                    d  = (hi == 0) ? 1 : $urandom_range(1, hi);
                end else if (pick < 50) begin
                    d = (19 * s) / 10 + 1;
                end else if (pick < 62) begin
                    d = longint'(s) * $urandom_range(2, 8);
                end else if (pick < 80) begin
                    d = longint'(s) * $urandom_range(1, 8) + $urandom_range(0, int'(s - 1));
                end else if (pick < 92) begin
                    d = longint'(s) * $urandom_range(20, 70) + $urandom_range(0, int'(s - 1));
                end else begin
                    d = $urandom;
                end
                nx = gen_cur + d;
                if (nx > OFS_MAX) nx = OFS_MAX;
                if (nx < OFS_MIN) nx = OFS_MIN;
                if (nx >= gen_cur) gen_cur = nx;
            end
            push_item(nx, i == len - 1);
        end
    endtask

    task automatic run_phase(int unsigned count);
        int unsigned pushed;
        int unsigned len;
        pushed = 0;
        while (pushed < count) begin
            len = $urandom_range(1, 10);
            push_line(len);
            pushed += len;
        end
        drain();
    endtask

    initial begin : stimulus
        longint a;
        logic [STEP_W-1:0] steps[8];
        steps[0] = STEP_W'(1);
        steps[1] = '0;
        steps[2] = {STEP_W{1'b1}};
        steps[3] = STEP_W'(19);
        steps[4] = STEP_W'(3);
        steps[5] = STEP_W'($urandom_range(1, 4096));
        steps[6] = STEP_W'($urandom);
        steps[7] = STEP_RESET;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: step at reset value 256
        a = OFS_MIN;
        push_item(a, 1'b0);
        push_item(a, 1'b0);
        a += 256;       push_item(a, 1'b0);
        a += 486;       push_item(a, 1'b0);
        a += 487;       push_item(a, 1'b0);
        a += 512;       push_item(a, 1'b0);
        a += 256 * 70;  push_item(a, 1'b0);
        push_item(a - 1, 1'b0);
        push_item(a - 5, 1'b1);
        push_item(OFS_MAX, 1'b1);
        push_item(0, 1'b0);
        push_item(OFS_MAX, 1'b0);
        push_item(-5, 1'b1);
        a = 1000;       push_item(a, 1'b0);
        a += 16384;     push_item(a, 1'b0);
        a += 16385;     push_item(a, 1'b0);
        a += 256 * 63 + 5; push_item(a, 1'b0);
        push_item(a, 1'b1);
        drain();

        for (int p = 0; p < 8; p++) begin
            idle_on = (p < 7);
            write_step(steps[p]);
            run_phase(PHASE_ITEMS);
        end

        if (axis_q.size() != 0)
            report_mismatch($sformatf("%0d expected transactions never arrived", axis_q.size()));

        $display("covered %0d offsets over %0d step settings, %0d results out",
                 n_items, n_cfg + 1, n_results);
        $display("fill points %0d, capped-run results %0d, order errors %0d, mismatches %0d",
                 n_fills, n_capped, n_order, n_mismatch);
        if (n_mismatch == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
